>>> rtl/bdq_pkg.sv
// shared types and constants for the bounded deque
package bdq_pkg;

    localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
    localparam logic [1:0] OP_PUSH_REAR  = 2'd1;
    localparam logic [1:0] OP_POP_FRONT  = 2'd2;
    localparam logic [1:0] OP_POP_REAR   = 2'd3;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic [7:0] CAP_RESET = 8'd128;

    typedef enum logic [0:0] {
        CTRL_IDLE,
        CTRL_READ
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic finish;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_read;
    } dp_status_t;

endpackage

>>> rtl/bdq_ram.sv
// generic single write port, single read port ram with registered read
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/bdq_ctrl.sv
// handshake controller for the bounded deque
module bdq_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  bdq_pkg::dp_status_t    dp_status,
    output bdq_pkg::dp_cmd_t       dp_cmd
);
    import bdq_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CTRL_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        // output register can take a new beat this cycle
        out_free      = !out_valid_reg || out_ready;
        state_next    = state_reg;
        in_ready      = 1'b0;
        dp_cmd.accept = 1'b0;
        dp_cmd.finish = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            CTRL_IDLE:
            begin
                in_ready      = out_free;
                dp_cmd.accept = in_valid && out_free;
                if (dp_cmd.accept)
                begin
                    if (dp_status.need_read)
                    begin
                        state_next = CTRL_READ;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                    end
                end
            end
            CTRL_READ:
            begin
                // ram data holds until the output slot frees up
                if (out_free)
                begin
                    dp_cmd.finish  = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = CTRL_IDLE;
                end
            end
            default:
            begin
                state_next = CTRL_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

>>> rtl/bdq_datapath.sv
// pointers, count, cached end words, entry ram and result register
module bdq_datapath #(
    parameter int DEPTH      = 128,
    parameter int DATA_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [7:0]          cfg_wr_data,
    input  logic [1:0]          opcode,
    input  logic signed [31:0]  push_value,
    input  bdq_pkg::dp_cmd_t    dp_cmd,
    output bdq_pkg::dp_status_t dp_status,
    output logic [1:0]          status,
    output logic [7:0]          entry_count,
    output logic signed [31:0]  front_value,
    output logic signed [31:0]  rear_value
);
    import bdq_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > 8) ? CW : 8;
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

    function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] idx);
        return (idx == LAST_SLOT) ? '0 : idx + 1'b1;
    endfunction

    function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] idx);
        return (idx == '0) ? LAST_SLOT : idx - 1'b1;
    endfunction

    logic [AW-1:0]         head_reg, head_next;
    logic [AW-1:0]         tail_reg, tail_next;
    logic [CW-1:0]         occ_reg, occ_next;
    logic [7:0]            cap_reg;
    logic [DATA_WIDTH-1:0] front_reg, front_next;
    logic [DATA_WIDTH-1:0] rear_reg, rear_next;
    logic                  pop_rear_reg, pop_rear_next;

    logic [1:0]            status_reg, status_next;
    logic [7:0]            count_out_reg, count_out_next;
    logic [DATA_WIDTH-1:0] front_out_reg, front_out_next;
    logic [DATA_WIDTH-1:0] rear_out_reg, rear_out_next;

    logic [DATA_WIDTH-1:0] word;
    logic [DATA_WIDTH-1:0] rd_data;
    logic [AW-1:0]         wr_addr, rd_addr;
    logic                  wr_req;
    logic                  need_read;
    logic                  is_full, is_empty;
    logic [CMPW-1:0]       occ_ext, occ_next_ext, occ_reg_ext;
    logic [AW-1:0]         tail_back;

    generate
        if (DATA_WIDTH <= 32)
        begin : g_word_narrow
            assign word = push_value[DATA_WIDTH-1:0];
        end
        else
        begin : g_word_wide
            assign word = {{(DATA_WIDTH - 32){push_value[31]}}, push_value};
        end
    endgenerate

    assign occ_ext   = CMPW'(occ_reg);
    assign is_full   = (occ_ext >= CMPW'(cap_reg)) || (occ_reg >= CW'(DEPTH));
    assign is_empty  = (occ_reg == '0);
    assign tail_back = slot_dec(tail_reg);

    always_comb
    begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        occ_next      = occ_reg;
        front_next    = front_reg;
        rear_next     = rear_reg;
        pop_rear_next = pop_rear_reg;
        status_next   = ST_DONE;
        wr_req        = 1'b0;
        wr_addr       = tail_reg;
        rd_addr       = head_reg;
        need_read     = 1'b0;
        case (opcode)
            OP_PUSH_FRONT:
            begin
                if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    head_next  = slot_dec(head_reg);
                    wr_req     = 1'b1;
                    wr_addr    = head_next;
                    occ_next   = occ_reg + 1'b1;
                    front_next = word;
                    if (is_empty)
                    begin
                        rear_next = word;
                    end
                end
            end
            OP_PUSH_REAR:
            begin
                if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    tail_next = slot_inc(tail_reg);
                    wr_req    = 1'b1;
                    wr_addr   = tail_reg;
                    occ_next  = occ_reg + 1'b1;
                    rear_next = word;
                    if (is_empty)
                    begin
                        front_next = word;
                    end
                end
            end
            OP_POP_FRONT:
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    head_next     = slot_inc(head_reg);
                    occ_next      = occ_reg - 1'b1;
                    rd_addr       = head_next;
                    need_read     = (occ_next != '0);
                    pop_rear_next = 1'b0;
                end
            end
            OP_POP_REAR:
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    tail_next     = tail_back;
                    occ_next      = occ_reg - 1'b1;
                    rd_addr       = slot_dec(tail_back);
                    need_read     = (occ_next != '0);
                    pop_rear_next = 1'b1;
                end
            end
            default:
            begin
                status_next = ST_DONE;
            end
        endcase
    end

    assign dp_status.need_read = need_read;
    assign occ_next_ext = CMPW'(occ_next);
    assign occ_reg_ext  = CMPW'(occ_reg);

    // result beat: taken at accept, or after the ram read for a pop
    always_comb
    begin
        if (dp_cmd.finish)
        begin
            count_out_next = occ_reg_ext[7:0];
            front_out_next = pop_rear_reg ? front_reg : rd_data;
            rear_out_next  = pop_rear_reg ? rd_data : rear_reg;
        end
        else
        begin
            count_out_next = occ_next_ext[7:0];
            front_out_next = (occ_next == '0) ? '0 : front_next;
            rear_out_next  = (occ_next == '0) ? '0 : rear_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            occ_reg  <= '0;
            cap_reg  <= CAP_RESET;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
            if (dp_cmd.accept)
            begin
                head_reg <= head_next;
                tail_reg <= tail_next;
                occ_reg  <= occ_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.accept)
        begin
            front_reg    <= front_next;
            rear_reg     <= rear_next;
            pop_rear_reg <= pop_rear_next;
            if (!need_read)
            begin
                status_reg    <= status_next;
                count_out_reg <= count_out_next;
                front_out_reg <= front_out_next;
                rear_out_reg  <= rear_out_next;
            end
        end
        else if (dp_cmd.finish)
        begin
            if (pop_rear_reg)
            begin
                rear_reg <= rd_data;
            end
            else
            begin
                front_reg <= rd_data;
            end
            status_reg    <= ST_DONE;
            count_out_reg <= count_out_next;
            front_out_reg <= front_out_next;
            rear_out_reg  <= rear_out_next;
        end
    end

    bdq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (dp_cmd.accept && wr_req),
        .wr_addr (wr_addr),
        .wr_data (word),
        .rd_en   (dp_cmd.accept && need_read),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign status      = status_reg;
    assign entry_count = count_out_reg;

    generate
        if (DATA_WIDTH >= 32)
        begin : g_out_wide
            assign front_value = front_out_reg[31:0];
            assign rear_value  = rear_out_reg[31:0];
        end
        else
        begin : g_out_narrow
            assign front_value = 32'(front_out_reg);
            assign rear_value  = 32'(rear_out_reg);
        end
    endgenerate

endmodule

>>> rtl/bounded_deque.sv
// top level of the bounded double-ended queue
//
// Bounded deque of signed words kept in a ring buffer of DEPTH entries held
// in a single ram. Each input beat carries an opcode (push front, push rear,
// pop front, pop rear) and gives exactly one result beat with the status,
// the new entry count and the words at the front and rear (zero when empty).
// Pushes, rejected operations and pops that empty the queue register their
// result on the accepting edge. A pop that leaves entries behind waits in
// the read state for the new front or rear word from the registered read
// port of the entry ram and for a free output slot. The output register
// lets a new beat in on the same edge that the waiting result leaves.
// capacity_limit may be changed only while the queue is idle; a limit above
// DEPTH acts as DEPTH and lowering it below the count keeps the entries
// already held.
module bounded_deque #(
    parameter int DEPTH      = 128,
    parameter int DATA_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [7:0]         cfg_wr_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         opcode,
    input  logic signed [31:0] push_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic [7:0]         entry_count,
    output logic signed [31:0] front_value,
    output logic signed [31:0] rear_value
);
    import bdq_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    bdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd)
    );

    bdq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .opcode      (opcode),
        .push_value  (push_value),
        .dp_cmd      (dp_cmd),
        .dp_status   (dp_status),
        .status      (status),
        .entry_count (entry_count),
        .front_value (front_value),
        .rear_value  (rear_value)
    );

endmodule

>>> tb/tb_top.sv
// self-checking testbench for the bounded double-ended queue
module tb_top;
    import bdq_pkg::*;

    localparam int DEPTH = 128;
    localparam int CLK_PERIOD = 12;
    localparam int DRAIN_CYCLES = 4;
    localparam int HOLD_CYCLES = 300;
    localparam int TIMEOUT_CYCLES = 400000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] word;
    } deque_cmd_t;

    typedef struct packed {
        logic [1:0]  st;
        logic [7:0]  cnt;
        logic [31:0] front;
        logic [31:0] rear;
    } deque_view_t;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [7:0]         cfg_wr_data = 8'd0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         opcode = OP_PUSH_FRONT;
    logic signed [31:0] push_value = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [1:0]         status;
    logic [7:0]         entry_count;
    logic signed [31:0] front_value;
    logic signed [31:0] rear_value;

    // stimulus and expectations
    deque_cmd_t  cmd_q[$];
    deque_view_t view_q[$];
    deque_cmd_t  drv_cmd;
    int          offer_cnt = 0;
    int          accept_cnt = 0;
    int          snd_idle_pct = 0;
    int          rcv_idle_pct = 0;
    bit          hold_req = 1'b0;
    int          hold_cnt = 0;

    // predictor state
    logic [31:0] ring [DEPTH];
    bit [6:0]    head_ix = '0;
    bit [6:0]    tail_ix = '0;
    int          held = 0;
    bit [7:0]    limit_reg = CAP_RESET;

    int errors = 0;
    int results_seen = 0;
    int n_full = 0;
    int n_empty = 0;
    int peak_held = 0;
    int limits_used = 0;

    bounded_deque #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (32)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .push_value  (push_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .entry_count (entry_count),
        .front_value (front_value),
        .rear_value  (rear_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("FAIL bounded_deque");
        $finish;
    end

    // apply one operation to the ring model and queue the view it leaves
    function automatic void deque_apply(input logic [1:0] op, input logic [31:0] word);
        deque_view_t v;
        bit [6:0]    rear_ix;
        v.st = ST_DONE;
        if (op == OP_PUSH_FRONT || op == OP_PUSH_REAR)
        begin
            if (held >= limit_reg || held >= DEPTH)
            begin
                v.st = ST_FULL;
                n_full++;
            end
            else if (op == OP_PUSH_FRONT)
            begin
                head_ix = head_ix - 7'd1;
                ring[head_ix] = word;
                held++;
            end
            else
            begin
                ring[tail_ix] = word;
                tail_ix = tail_ix + 7'd1;
                held++;
            end
        end
        else
        begin
            if (held == 0)
            begin
                v.st = ST_EMPTY;
                n_empty++;
            end
            else if (op == OP_POP_FRONT)
            begin
                head_ix = head_ix + 7'd1;
                held--;
            end
            else
            begin
                tail_ix = tail_ix - 7'd1;
                held--;
            end
        end
        if (held > peak_held)
            peak_held = held;
        rear_ix = tail_ix - 7'd1;
        v.cnt = held[7:0];
        v.front = (held == 0) ? 32'd0 : ring[head_ix];
        v.rear = (held == 0) ? 32'd0 : ring[rear_ix];
        view_q.push_back(v);
    endfunction

    function automatic void add_cmd(input logic [1:0] op, input logic [31:0] word);
        deque_cmd_t c;
        c.op = op;
        c.word = word;
        cmd_q.push_back(c);
    endfunction

    // random operations, pushes taking push_pct percent of them
    function automatic void add_random(input int n, input int push_pct);
        logic [31:0] word;
        logic [1:0]  op;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(9))
                0: word = 32'h7fff_ffff;
                1: word = 32'h8000_0000;
                2: word = ($urandom_range(1) != 0) ? 32'hffff_ffff : 32'd0;
                default: word = $urandom;
            endcase
            if ($urandom_range(99) < push_pct)
                op = ($urandom_range(1) != 0) ? OP_PUSH_REAR : OP_PUSH_FRONT;
            else
                op = ($urandom_range(1) != 0) ? OP_POP_REAR : OP_POP_FRONT;
            add_cmd(op, word);
        end
    endfunction

    // wait until every beat is sent and every result is back, then let the block settle
    task automatic wait_drained();
        do
            @(negedge clk);
        while (cmd_q.size() != 0 || in_valid || view_q.size() != 0 || out_valid);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_limit(input logic [7:0] lim);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= lim;
        limit_reg = lim;
        limits_used++;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_idle(input int snd_pct, input int rcv_pct);
        @(posedge clk);
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
    endtask

    // sender
    always @(negedge clk)
    begin
        if (!in_valid || accept_cnt == offer_cnt)
        begin
            if (cmd_q.size() != 0 && $urandom_range(99) >= snd_idle_pct)
            begin
                drv_cmd = cmd_q.pop_front();
                in_valid <= 1'b1;
                opcode <= drv_cmd.op;
                push_value <= drv_cmd.word;
                offer_cnt <= offer_cnt + 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver, with one long hold-off when requested
    always @(negedge clk)
    begin
        if (hold_req && hold_cnt < HOLD_CYCLES)
        begin
            out_ready <= 1'b0;
            hold_cnt <= hold_cnt + 1;
        end
        else
            out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    // result check and prediction on accepted beats
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (view_q.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("unexpected result beat: st=%0d cnt=%0d front=%h rear=%h",
                                 status, entry_count, front_value, rear_value);
                end
                else
                begin
                    deque_view_t want;
                    want = view_q.pop_front();
                    if (status !== want.st || entry_count !== want.cnt ||
                        front_value !== want.front || rear_value !== want.rear)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                        begin
                            $display("result %0d mismatch: expected st=%0d cnt=%0d front=%h rear=%h",
                                     results_seen, want.st, want.cnt, want.front, want.rear);
                            $display("    got st=%0d cnt=%0d front=%h rear=%h",
                                     status, entry_count, front_value, rear_value);
                        end
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                accept_cnt <= accept_cnt + 1;
                deque_apply(opcode, push_value);
            end
        end
    end

    initial
    begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // sender idles 20%, receiver 49%
        set_idle(20, 49);
        write_limit(CAP_RESET);
        @(posedge clk);
        // empty pops, pushes at both ends with extreme words, drain from both ends
        add_cmd(OP_POP_FRONT, 32'h1111_1111);
        add_cmd(OP_POP_REAR, 32'h2222_2222);
        add_cmd(OP_PUSH_FRONT, 32'h7fff_ffff);
        add_cmd(OP_PUSH_REAR, 32'h8000_0000);
        add_cmd(OP_PUSH_FRONT, 32'h0000_0000);
        add_cmd(OP_PUSH_REAR, 32'hffff_ffff);
        add_cmd(OP_POP_FRONT, 32'd0);
        add_cmd(OP_POP_REAR, 32'd0);
        add_cmd(OP_POP_FRONT, 32'd0);
        add_cmd(OP_POP_REAR, 32'd0);
        add_cmd(OP_POP_REAR, 32'd0);
        add_cmd(OP_PUSH_REAR, 32'h1234_5678);
        add_cmd(OP_POP_FRONT, 32'd0);
        add_cmd(OP_PUSH_FRONT, 32'ha5a5_a5a5);
        add_cmd(OP_POP_REAR, 32'd0);
        wait_drained();

        // limit of one: second push hits full
        write_limit(8'd1);
        @(posedge clk);
        add_cmd(OP_PUSH_FRONT, 32'd1);
        add_cmd(OP_PUSH_REAR, 32'd2);
        add_cmd(OP_PUSH_FRONT, 32'd3);
        add_cmd(OP_POP_FRONT, 32'd0);
        add_cmd(OP_POP_REAR, 32'd0);
        add_cmd(OP_PUSH_REAR, 32'h55aa_55aa);
        add_cmd(OP_POP_REAR, 32'd0);
        add_random(150, 50);
        wait_drained();

        // zero limit rejects every push
        write_limit(8'd0);
        @(posedge clk);
        add_random(60, 60);
        wait_drained();

        // limit above depth acts as depth; push-heavy so the ring fills and wraps
        write_limit(8'd255);
        @(posedge clk);
        add_random(250, 75);
        add_random(100, 25);
        wait_drained();

        // sender idles 49%, receiver 20%
        set_idle(49, 20);
        write_limit(CAP_RESET);
        @(posedge clk);
        add_random(300, 65);
        wait_drained();

        // limit dropped below the current count, entries kept
        write_limit(8'd5);
        @(posedge clk);
        add_random(200, 50);
        wait_drained();

        write_limit(8'd100);
        @(posedge clk);
        add_random(300, 55);
        wait_drained();

        // no idling; receiver stalls for a long stretch so the input backs up
        set_idle(0, 0);
        write_limit(CAP_RESET);
        @(posedge clk);
        hold_req = 1'b1;
        add_random(250, 60);
        wait_drained();

        write_limit(8'd37);
        @(posedge clk);
        add_random(250, 50);
        wait_drained();

        $display("covered %0d beats in %0d limit settings (0, 1, 5, 37, 100, 128, 255)",
                 accept_cnt, limits_used);
        $display("results checked %0d, full rejects %0d, empty rejects %0d, peak count %0d",
                 results_seen, n_full, n_empty, peak_held);
        if (errors == 0)
            $display("PASS bounded_deque");
        else
            $display("FAIL bounded_deque");
        $finish;
    end

endmodule
